// ----- src/ldpr_pkg.sv -----
// Shared types, constants and helper functions for the dirty pixel refresh block.
// Used by the top level; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package ldpr_pkg;

    localparam int SHADOW_DEPTH = 262144;
    localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);
    localparam int COORD_BITS   = 12;
    localparam int PIXEL_W      = 16;

    localparam logic [4:0] CODE_CMD_FIRST   = 5'h11;
    localparam logic [4:0] CODE_CMD_SECOND  = 5'h1B;
    localparam logic [4:0] CODE_DATA_FIRST  = 5'h15;
    localparam logic [4:0] CODE_DATA_SECOND = 5'h1F;

    localparam logic [15:0] CMD_PAGE_ADDR = 16'h002B;
    localparam logic [15:0] CMD_COL_ADDR  = 16'h002A;
    localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;

    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_ROW_END    = 2'd1;
    localparam logic [1:0] CFG_COL_END    = 2'd2;
    localparam logic [1:0] CFG_FULL_COPY  = 2'd3;

    // Transfer sequence of one pixel: first window, pixel word, row-wrap window.
    localparam logic [5:0] STEP_WIN1 = 6'd0;
    localparam logic [5:0] STEP_PIX  = 6'd22;
    localparam logic [5:0] STEP_WIN2 = 6'd24;
    localparam logic [5:0] STEP_END  = 6'd46;
    localparam logic [5:0] STEP_NONE = 6'd63;

    typedef struct packed {
        logic        is_cmd;
        logic [15:0] value;
    } bus_word_t;

    function automatic bus_word_t window_word(
        input logic [3:0]  k,
        input logic [15:0] col,
        input logic [15:0] row,
        input logic [15:0] row_end,
        input logic [15:0] col_end
    );
        bus_word_t w;
        w.is_cmd = 1'b0;
        w.value  = 16'h0000;
        case (k)
            4'd0: begin
                w.is_cmd = 1'b1;
                w.value  = CMD_PAGE_ADDR;
            end
            4'd1: w.value = {8'h00, row[15:8]};
            4'd2: w.value = {8'h00, row[7:0]};
            4'd3: w.value = {8'h00, row_end[15:8]};
            4'd4: w.value = {8'h00, row_end[7:0]};
            4'd5: begin
                w.is_cmd = 1'b1;
                w.value  = CMD_COL_ADDR;
            end
            4'd6: w.value = {8'h00, col[15:8]};
            4'd7: w.value = {8'h00, col[7:0]};
            4'd8: w.value = {8'h00, col_end[15:8]};
            4'd9: w.value = {8'h00, col_end[7:0]};
            4'd10: begin
                w.is_cmd = 1'b1;
                w.value  = CMD_MEM_WRITE;
            end
            default: begin
                w.is_cmd = 1'b0;
                w.value  = 16'h0000;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/ldpr_shadow_ram.sv -----
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Read-first: a read and a write of the same entry in one cycle return the old data.
`timescale 1ns / 1ps
`default_nettype none

module ldpr_shadow_ram #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/lcd_dirty_pixel_refresh_top.sv -----
// Top level of the LCD dirty pixel refresh block: position counters, shadow compare and
// the transfer sequencer. Depends on ldpr_pkg and ldpr_shadow_ram.
`timescale 1ns / 1ps
`default_nettype none

// Pixels arrive in raster order and each one is checked against a shadow frame held in a
// single-port-read, single-port-write RAM with a registered read port. When a
// transaction is accepted, the shadow entry is read in that cycle and compared in the
// next, and the results leave through a registered output at one bus transfer per
// cycle unless the output stalls. A pixel gives 2 transfers for a plain pixel word, 22
// for a row-wrap window set-up sent alone, 24 or 46 when one or two window set-ups go
// with a pixel word, and none when nothing is sent. It holds the sequencer until its
// last transfer is registered. A new transaction is taken in the cycle the previous one
// finishes. Back-to-back accesses to the same shadow entry are forwarded. The shadow
// frame is not cleared at reset, so delta mode expects one full pass first.
module lcd_dirty_pixel_refresh_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_pixel,
    input  wire logic        s_run_start,
    input  wire logic        s_frame_start,
    input  wire logic [11:0] s_start_x,
    input  wire logic [11:0] s_start_y,
    input  wire logic [17:0] s_start_address,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_word_high,
    output logic [7:0]       m_word_low,
    output logic [4:0]       m_control_code,
    output logic             m_last
);

    localparam int AW = ldpr_pkg::SHADOW_AW;
    localparam int CW = ldpr_pkg::COORD_BITS;
    localparam int PW = ldpr_pkg::PIXEL_W;

    // Configuration.
    logic [11:0] line_width_reg;
    logic [15:0] row_end_reg;
    logic [15:0] col_end_reg;
    logic        full_copy_reg;

    // Position state.
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [CW-1:0] row_count_reg, row_count_next;
    logic [AW-1:0] shadow_index_reg, shadow_index_next;
    logic          need_position_reg, need_position_next;

    // Compare and sequencer stage.
    logic          b_valid_reg, b_valid_next;
    logic          b_fresh_reg, b_fresh_next;
    logic [5:0]    b_step_reg, b_step_next;
    logic [PW-1:0] b_pixel_reg;
    logic [AW-1:0] b_idx_reg;
    logic          b_run_start_reg;
    logic          b_frame_start_reg;
    logic [CW-1:0] b_col_reg;
    logic [CW-1:0] b_row_reg;
    logic          b_wrap_reg;
    logic [CW-1:0] b_wrow_reg;
    logic          b_fwd_reg;
    logic [PW-1:0] b_fwd_data_reg;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_word_high_reg;
    logic [7:0] m_word_low_reg;
    logic [4:0] m_control_code_reg;
    logic       m_last_reg;

    logic          s_accept;
    logic [AW-1:0] a_idx;
    logic [CW-1:0] a_col, a_row, a_col_inc, a_row_inc;
    logic          a_wrap;
    logic          fwd_hit;

    logic [PW-1:0] ram_rdata;
    logic [PW-1:0] shadow_q;
    logic          pix_equal;
    logic          np_eff;
    logic          en_win1, en_pix, en_win2;
    logic          b_we;
    logic [5:0]    first_step, cur_step, nxt_step, step_inc;
    logic          no_output, is_last, emit, out_free, b_done;

    logic          in_pix, in_win2;
    logic [5:0]    win_off;
    logic [15:0]   win_col, win_row;
    ldpr_pkg::bus_word_t win_word;
    logic          word_cmd;
    logic [15:0]   word_value;
    logic [4:0]    word_code;

    // Accept stage: position bookkeeping and shadow read.
    always_comb begin
        s_accept = s_valid & s_ready;
        a_idx    = s_run_start ? AW'(s_start_address) : shadow_index_reg;
        a_col    = s_run_start ? CW'(s_start_x) : col_count_reg;
        a_row    = s_run_start ? CW'(s_start_y) : row_count_reg;
        a_col_inc = a_col + 1'b1;
        a_row_inc = a_row + 1'b1;
        a_wrap    = (17'(a_col_inc) >= 17'(line_width_reg));
        fwd_hit   = b_done & b_we & (b_idx_reg == a_idx);

        col_count_next    = col_count_reg;
        row_count_next    = row_count_reg;
        shadow_index_next = shadow_index_reg;
        if (s_accept) begin
            shadow_index_next = a_idx + 1'b1;
            if (full_copy_reg) begin
                col_count_next = a_col;
                row_count_next = a_row;
            end else begin
                col_count_next = a_wrap ? '0 : a_col_inc;
                row_count_next = a_wrap ? a_row_inc : a_row;
            end
        end
    end

    ldpr_shadow_ram #(
        .ADDR_W(AW),
        .DATA_W(PW)
    ) u_shadow_ram (
        .aclk   (aclk),
        .wr_en  (b_done & b_we),
        .wr_addr(b_idx_reg),
        .wr_data(b_pixel_reg),
        .rd_en  (s_accept),
        .rd_addr(a_idx),
        .rd_data(ram_rdata)
    );

    // Compare stage and transfer sequencer.
    always_comb begin
        shadow_q  = b_fwd_reg ? b_fwd_data_reg : ram_rdata;
        pix_equal = (shadow_q == b_pixel_reg);
        np_eff    = b_run_start_reg | need_position_reg;

        if (full_copy_reg) begin
            en_win1 = b_frame_start_reg;
            en_pix  = 1'b1;
            en_win2 = 1'b0;
            b_we    = 1'b1;
        end else begin
            en_win1 = ~pix_equal & np_eff;
            en_pix  = ~pix_equal;
            en_win2 = b_wrap_reg;
            b_we    = ~pix_equal;
        end

        if (en_win1) begin
            first_step = ldpr_pkg::STEP_WIN1;
        end else if (en_pix) begin
            first_step = ldpr_pkg::STEP_PIX;
        end else if (en_win2) begin
            first_step = ldpr_pkg::STEP_WIN2;
        end else begin
            first_step = ldpr_pkg::STEP_NONE;
        end

        cur_step = b_fresh_reg ? first_step : b_step_reg;
        step_inc = cur_step + 1'b1;
        nxt_step = step_inc;
        if (nxt_step == ldpr_pkg::STEP_PIX && !en_pix) begin
            nxt_step = ldpr_pkg::STEP_WIN2;
        end
        if (nxt_step == ldpr_pkg::STEP_WIN2 && !en_win2) begin
            nxt_step = ldpr_pkg::STEP_NONE;
        end
        if (nxt_step == ldpr_pkg::STEP_END) begin
            nxt_step = ldpr_pkg::STEP_NONE;
        end

        no_output = (cur_step == ldpr_pkg::STEP_NONE);
        is_last   = (nxt_step == ldpr_pkg::STEP_NONE);
        out_free  = ~m_valid_reg | m_ready;
        emit      = b_valid_reg & ~no_output & out_free;
        b_done    = b_valid_reg & (no_output | (emit & is_last));
        s_ready   = ~b_valid_reg | b_done;

        in_pix  = (cur_step >= ldpr_pkg::STEP_PIX) && (cur_step < ldpr_pkg::STEP_WIN2);
        in_win2 = (cur_step >= ldpr_pkg::STEP_WIN2);
        win_off = in_win2 ? (cur_step - ldpr_pkg::STEP_WIN2) : cur_step;
        win_col = in_win2 ? 16'h0000 : 16'(b_col_reg);
        win_row = in_win2 ? 16'(b_wrow_reg) : 16'(b_row_reg);
        win_word = ldpr_pkg::window_word(win_off[4:1], win_col, win_row,
                                         row_end_reg, col_end_reg);
        word_cmd   = in_pix ? 1'b0 : win_word.is_cmd;
        word_value = in_pix ? b_pixel_reg : win_word.value;
        if (word_cmd) begin
            word_code = cur_step[0] ? ldpr_pkg::CODE_CMD_SECOND : ldpr_pkg::CODE_CMD_FIRST;
        end else begin
            word_code = cur_step[0] ? ldpr_pkg::CODE_DATA_SECOND : ldpr_pkg::CODE_DATA_FIRST;
        end

        b_valid_next = b_valid_reg;
        b_fresh_next = b_fresh_reg;
        b_step_next  = b_step_reg;
        if (emit) begin
            b_fresh_next = 1'b0;
            b_step_next  = nxt_step;
        end
        if (b_done) begin
            b_valid_next = 1'b0;
        end
        if (s_accept) begin
            b_valid_next = 1'b1;
            b_fresh_next = 1'b1;
        end

        need_position_next = need_position_reg;
        if (b_done) begin
            need_position_next = full_copy_reg ? np_eff : pix_equal;
        end

        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg    <= 12'd480;
            row_end_reg       <= 16'd319;
            col_end_reg       <= 16'd479;
            full_copy_reg     <= 1'b1;
            col_count_reg     <= '0;
            row_count_reg     <= '0;
            shadow_index_reg  <= '0;
            need_position_reg <= 1'b1;
            b_valid_reg       <= 1'b0;
            b_fresh_reg       <= 1'b0;
            b_step_reg        <= ldpr_pkg::STEP_NONE;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    ldpr_pkg::CFG_LINE_WIDTH: line_width_reg <= cfg_wdata[11:0];
                    ldpr_pkg::CFG_ROW_END:    row_end_reg    <= cfg_wdata;
                    ldpr_pkg::CFG_COL_END:    col_end_reg    <= cfg_wdata;
                    ldpr_pkg::CFG_FULL_COPY:  full_copy_reg  <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            col_count_reg     <= col_count_next;
            row_count_reg     <= row_count_next;
            shadow_index_reg  <= shadow_index_next;
            need_position_reg <= need_position_next;
            b_valid_reg       <= b_valid_next;
            b_fresh_reg       <= b_fresh_next;
            b_step_reg        <= b_step_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_pixel_reg       <= s_pixel;
            b_idx_reg         <= a_idx;
            b_run_start_reg   <= s_run_start;
            b_frame_start_reg <= s_frame_start;
            b_col_reg         <= full_copy_reg ? '0 : a_col;
            b_row_reg         <= full_copy_reg ? '0 : a_row;
            b_wrap_reg        <= a_wrap;
            b_wrow_reg        <= a_row_inc;
            b_fwd_reg         <= fwd_hit;
            b_fwd_data_reg    <= b_pixel_reg;
        end
        if (emit) begin
            m_word_high_reg    <= word_value[15:8];
            m_word_low_reg     <= word_value[7:0];
            m_control_code_reg <= word_code;
            m_last_reg         <= is_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_word_high    = m_word_high_reg;
    assign m_word_low     = m_word_low_reg;
    assign m_control_code = m_control_code_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for lcd_dirty_pixel_refresh_top: full and delta refresh of RGB565
// pixels against a shadow frame, with random idling on both handshakes.
// Depends on ldpr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [15:0] pixel;
        logic        run_start;
        logic        frame_start;
        logic [11:0] start_x;
        logic [11:0] start_y;
        logic [17:0] start_address;
    } pixel_item_t;

    typedef struct {
        logic [7:0] word_high;
        logic [7:0] word_low;
        logic [4:0] code;
        logic       last;
    } bus_xfer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = ldpr_pkg::CFG_LINE_WIDTH;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_word_high;
    logic [7:0]  m_word_low;
    logic [4:0]  m_control_code;
    logic        m_last;

    pixel_item_t cur_pixel = '{16'h0000, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000};

    pixel_item_t pending_pixels[$];
    bus_xfer_t   xfers_due[$];
    bus_xfer_t   pixel_burst[$];

    // Mirror of the block's registers and position state.
    logic [11:0]                    cfg_line_width = 12'd480;
    logic [15:0]                    cfg_row_end = 16'd319;
    logic [15:0]                    cfg_col_end = 16'd479;
    logic                           cfg_full = 1'b1;
    logic [11:0]                    col_cnt = 12'd0;
    logic [11:0]                    row_cnt = 12'd0;
    logic [ldpr_pkg::SHADOW_AW-1:0] shadow_ptr = '0;
    logic                           need_window = 1'b1;
    logic [15:0]                    shadow_mem[int];

    // Stimulus side bookkeeping of which shadow entries hold data.
    int          gen_idx = 0;
    logic [15:0] gen_pix[int];
    int          written_addrs[$];

    bit quiet = 1'b0;
    int in_gap = 0;
    int out_stall = 0;
    int errors = 0;
    int pixels_taken = 0;
    int xfers_checked = 0;
    int cfg_writes = 0;
    int cycles = 0;

    logic [15:0] s_pixel_w;
    logic        s_run_start_w;
    logic        s_frame_start_w;

    assign {s_pixel_w, s_run_start_w, s_frame_start_w} =
        {cur_pixel.pixel, cur_pixel.run_start, cur_pixel.frame_start};

    lcd_dirty_pixel_refresh_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel_w),
        .s_run_start     (s_run_start_w),
        .s_frame_start   (s_frame_start_w),
        .s_start_x       (cur_pixel.start_x),
        .s_start_y       (cur_pixel.start_y),
        .s_start_address (cur_pixel.start_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word_high     (m_word_high),
        .m_word_low      (m_word_low),
        .m_control_code  (m_control_code),
        .m_last          (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d transfers outstanding", $time, xfers_due.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_word(input logic [15:0] v, input bit is_cmd);
        bus_xfer_t x;
        x.word_high = v[15:8];
        x.word_low  = v[7:0];
        x.code      = is_cmd ? ldpr_pkg::CODE_CMD_FIRST : ldpr_pkg::CODE_DATA_FIRST;
        x.last      = 1'b0;
        pixel_burst.push_back(x);
        x.code = is_cmd ? ldpr_pkg::CODE_CMD_SECOND : ldpr_pkg::CODE_DATA_SECOND;
        pixel_burst.push_back(x);
    endtask

    task automatic queue_window(input logic [15:0] col, input logic [15:0] row);
        queue_word(ldpr_pkg::CMD_PAGE_ADDR, 1'b1);
        queue_word({8'h00, row[15:8]}, 1'b0);
        queue_word({8'h00, row[7:0]}, 1'b0);
        queue_word({8'h00, cfg_row_end[15:8]}, 1'b0);
        queue_word({8'h00, cfg_row_end[7:0]}, 1'b0);
        queue_word(ldpr_pkg::CMD_COL_ADDR, 1'b1);
        queue_word({8'h00, col[15:8]}, 1'b0);
        queue_word({8'h00, col[7:0]}, 1'b0);
        queue_word({8'h00, cfg_col_end[15:8]}, 1'b0);
        queue_word({8'h00, cfg_col_end[7:0]}, 1'b0);
        queue_word(ldpr_pkg::CMD_MEM_WRITE, 1'b1);
    endtask

    task automatic pixel_to_xfers(input pixel_item_t it);
        logic [15:0] stored;
        bus_xfer_t   x;
        pixel_burst.delete();
        if (it.run_start) begin
            col_cnt     = it.start_x;
            row_cnt     = it.start_y;
            shadow_ptr  = it.start_address;
            need_window = 1'b1;
        end
        if (cfg_full) begin
            if (it.frame_start)
                queue_window(16'h0000, 16'h0000);
            queue_word(it.pixel, 1'b0);
            shadow_mem[shadow_ptr] = it.pixel;
        end else begin
            stored = shadow_mem.exists(shadow_ptr) ? shadow_mem[shadow_ptr] : 16'h0000;
            if (stored == it.pixel) begin
                need_window = 1'b1;
            end else begin
                if (need_window) begin
                    queue_window({4'h0, col_cnt}, {4'h0, row_cnt});
                    need_window = 1'b0;
                end
                queue_word(it.pixel, 1'b0);
                shadow_mem[shadow_ptr] = it.pixel;
            end
            col_cnt = col_cnt + 12'd1;
            if (col_cnt >= cfg_line_width) begin
                row_cnt = row_cnt + 12'd1;
                col_cnt = 12'd0;
                queue_window(16'h0000, {4'h0, row_cnt});
            end
        end
        shadow_ptr = shadow_ptr + 1'b1;
        if (pixel_burst.size() > 0) begin
            x = pixel_burst.pop_back();
            x.last = 1'b1;
            pixel_burst.push_back(x);
        end
        foreach (pixel_burst[i])
            xfers_due.push_back(pixel_burst[i]);
    endtask

    always @(posedge aclk) begin : drive_pixels
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pixel_to_xfers(cur_pixel);
                pixels_taken++;
            end
            if (!s_valid || s_ready) begin
                if (in_gap == 0 && !quiet && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 9);
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    cur_pixel <= pending_pixels.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int due, input int got);
        if (due != got) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, due, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch_bus
        bus_xfer_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                xfers_checked++;
                if (xfers_due.size() == 0) begin
                    $display("%0t unexpected transfer: expected none, actual %h %h %h %b",
                             $time, m_word_high, m_word_low, m_control_code, m_last);
                    errors++;
                end else begin
                    due = xfers_due.pop_front();
                    check_field("word_high", int'(due.word_high), int'(m_word_high));
                    check_field("word_low", int'(due.word_low), int'(m_word_low));
                    check_field("control_code", int'(due.code), int'(m_control_code));
                    check_field("last", int'(due.last), int'(m_last));
                end
            end
            if (out_stall == 0 && !quiet && $urandom_range(0, 9) == 0)
                out_stall = $urandom_range(1, 9);
            if (out_stall > 0) begin
                out_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_pixels.size() != 0 || s_valid || xfers_due.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            ldpr_pkg::CFG_LINE_WIDTH: cfg_line_width = val[11:0];
            ldpr_pkg::CFG_ROW_END:    cfg_row_end = val;
            ldpr_pkg::CFG_COL_END:    cfg_col_end = val;
            ldpr_pkg::CFG_FULL_COPY:  cfg_full = val[0];
            default: ;
        endcase
    endtask

    task automatic add_pixel(input logic [15:0] px, input bit rs, input bit fs,
                             input logic [11:0] x, input logic [11:0] y,
                             input logic [17:0] addr);
        pixel_item_t it;
        it = '{px, rs, fs, x, y, addr};
        pending_pixels.push_back(it);
        if (rs)
            gen_idx = int'(addr);
        if (!gen_pix.exists(gen_idx))
            written_addrs.push_back(gen_idx);
        gen_pix[gen_idx] = px;
        gen_idx = (gen_idx + 1) % ldpr_pkg::SHADOW_DEPTH;
    endtask

    task automatic full_pixel();
        logic [17:0] addr;
        addr = ($urandom_range(0, 3) == 0)
             ? 18'($urandom_range(ldpr_pkg::SHADOW_DEPTH - 4, ldpr_pkg::SHADOW_DEPTH - 1))
             : 18'($urandom_range(0, ldpr_pkg::SHADOW_DEPTH - 1));
        add_pixel(16'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0,
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), addr);
    endtask

    // Runs in delta mode only touch entries already written; a run leaving that area
    // is broken by a jump back into it.
    task automatic delta_pixel(input int match_pct);
        bit          rs;
        int          idx;
        logic [17:0] addr;
        logic [11:0] x;
        logic [15:0] px;
        rs   = !gen_pix.exists(gen_idx) || $urandom_range(0, 9) == 0;
        addr = rs ? 18'(written_addrs[$urandom_range(0, written_addrs.size() - 1)])
                  : 18'($urandom_range(0, ldpr_pkg::SHADOW_DEPTH - 1));
        idx  = rs ? int'(addr) : gen_idx;
        px   = ($urandom_range(0, 99) < match_pct) ? gen_pix[idx] : 16'($urandom);
        x    = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
                                    : 12'($urandom_range(4088, 4095));
        add_pixel(px, rs, $urandom_range(0, 3) == 0, x, 12'($urandom_range(0, 4095)), addr);
    endtask

    task automatic run_phase(input int count, input int match_pct);
        @(negedge aclk);
        repeat (count) begin
            if (cfg_full)
                full_pixel();
            else
                delta_pixel(match_pct);
        end
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_pixel(16'h0000, 1'b1, 1'b1, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'hFFFF, 1'b0, 1'b0, 12'hFFF, 12'hFFF, 18'h3FFFF);
        add_pixel(16'h8001, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'h1234, 1'b1, 1'b0, 12'hFFF, 12'hFFF, 18'h3FFFE);
        add_pixel(16'hA5A5, 1'b0, 1'b1, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'h5A5A, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'h0F0F, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'hC3C3, 1'b1, 1'b0, 12'h000, 12'h000, 18'h3FFFF);
        wait_idle();

        write_reg(ldpr_pkg::CFG_FULL_COPY, 16'd0);
        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'd4);
        write_reg(ldpr_pkg::CFG_ROW_END, 16'hFFFF);
        write_reg(ldpr_pkg::CFG_COL_END, 16'h0000);
        @(negedge aclk);
        add_pixel(gen_pix[ldpr_pkg::SHADOW_DEPTH - 2], 1'b1, 1'b0, 12'h000, 12'h000,
                  18'h3FFFE);
        add_pixel(16'hFFFF, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'h0000, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(gen_pix[1], 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(gen_pix[2], 1'b0, 1'b1, 12'h000, 12'h000, 18'h00000);
        add_pixel(16'h0001, 1'b1, 1'b0, 12'hFFF, 12'hFFF, 18'h00000);
        add_pixel(16'hFFFF, 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        add_pixel(gen_pix[2], 1'b0, 1'b0, 12'h000, 12'h000, 18'h00000);
        wait_idle();

        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'd1);
        @(negedge aclk);
        add_pixel(~gen_pix[ldpr_pkg::SHADOW_DEPTH - 2], 1'b1, 1'b0, 12'h800, 12'h7FF,
                  18'h3FFFE);
        add_pixel(gen_pix[ldpr_pkg::SHADOW_DEPTH - 1], 1'b0, 1'b0, 12'h000, 12'h000,
                  18'h00000);
        add_pixel(16'h7E7E, 1'b0, 1'b1, 12'h000, 12'h000, 18'h00000);
        wait_idle();

        write_reg(ldpr_pkg::CFG_FULL_COPY, 16'd1);
        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'd4095);
        write_reg(ldpr_pkg::CFG_ROW_END, 16'h0000);
        write_reg(ldpr_pkg::CFG_COL_END, 16'hFFFF);
        run_phase(30, 0);

        write_reg(ldpr_pkg::CFG_FULL_COPY, 16'd0);
        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'($urandom_range(2, 12)));
        write_reg(ldpr_pkg::CFG_ROW_END, 16'($urandom));
        write_reg(ldpr_pkg::CFG_COL_END, 16'($urandom));
        run_phase(40, 50);

        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'd4095);
        run_phase(25, 30);

        write_reg(ldpr_pkg::CFG_FULL_COPY, 16'd1);
        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'($urandom_range(1, 4095)));
        run_phase(15, 0);

        write_reg(ldpr_pkg::CFG_FULL_COPY, 16'd0);
        write_reg(ldpr_pkg::CFG_LINE_WIDTH, 16'($urandom_range(1, 6)));
        write_reg(ldpr_pkg::CFG_ROW_END, 16'($urandom));
        write_reg(ldpr_pkg::CFG_COL_END, 16'($urandom));
        quiet = 1'b1;
        run_phase(30, 40);

        $display("summary: %0d pixels in full and delta mode, %0d bus transfers checked",
                 pixels_taken, xfers_checked);
        $display("summary: %0d register writes, %0d shadow entries touched",
                 cfg_writes, written_addrs.size());
        if (errors == 0 && xfers_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d transfers never seen", errors, xfers_due.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/ldpr_pkg.sv
src/ldpr_shadow_ram.sv
src/lcd_dirty_pixel_refresh_top.sv
test/tb.sv
